/* src/stac_pkg.sv */
// shared constants, codes and control types for the shadow tag access checker
`default_nettype none

package stac_pkg;

    // shadow store geometry
    localparam int SHADOW_DEPTH = 4096;
    localparam int IDX_W        = $clog2(SHADOW_DEPTH);

    // field widths
    localparam int ADDR_W    = 64;
    localparam int CNT_W     = 13;
    localparam int TAG_W     = 2;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // stream packing
    localparam int S_ADDR_LO  = 0;
    localparam int S_CNT_LO   = S_ADDR_LO + ADDR_W;
    localparam int S_TAG_LO   = S_CNT_LO + CNT_W;
    localparam int S_USED_W   = S_TAG_LO + TAG_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_USED_W   = STATUS_W + CNT_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // request modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PROBE = 2'd3;

    // shadow tags
    localparam logic [TAG_W-1:0] TAG_VALID    = 2'd0;
    localparam logic [TAG_W-1:0] TAG_FREED    = 2'd1;
    localparam logic [TAG_W-1:0] TAG_NOTALLOC = 2'd2;
    localparam logic [TAG_W-1:0] TAG_UNINIT   = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UAF     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNALLOC = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNINIT  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DFREE   = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LIMIT  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic prep;
        logic run;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic pre_done;
        logic run_done;
    } sts_t;

endpackage

`default_nettype wire

/* src/stac_datapath.sv */
// datapath: config registers, shadow tag memory, byte walk and result registers
`default_nettype none

module stac_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire stac_pkg::cmd_t                     cmd,
    output stac_pkg::sts_t                          sts,
    input  wire logic [stac_pkg::MODE_W-1:0]        in_mode,
    input  wire logic [stac_pkg::ADDR_W-1:0]        in_access_address,
    input  wire logic [stac_pkg::CNT_W-1:0]         in_byte_count,
    input  wire logic [stac_pkg::TAG_W-1:0]         in_fill_tag,
    input  wire logic                               cfg_we,
    input  wire logic [stac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stac_pkg::CFG_W-1:0]         cfg_wdata,
    output logic      [stac_pkg::STATUS_W-1:0]      out_status,
    output logic      [stac_pkg::CNT_W-1:0]         out_fault_offset
);

    // shadow tag memory
    logic [stac_pkg::TAG_W-1:0] mem [stac_pkg::SHADOW_DEPTH];

    // config
    logic                          cen_reg;
    logic [stac_pkg::ADDR_W-1:0]   base_reg;
    logic [stac_pkg::ADDR_W-1:0]   limit_reg;

    // captured request
    logic [stac_pkg::MODE_W-1:0]   mode_reg;
    logic [stac_pkg::ADDR_W-1:0]   addr_reg;
    logic [stac_pkg::CNT_W-1:0]    count_reg;
    logic [stac_pkg::TAG_W-1:0]    tag_reg;

    // issue pointer
    logic [stac_pkg::ADDR_W-1:0]   cur_idx_reg;
    logic [stac_pkg::CNT_W-1:0]    cur_off_reg;

    // tag check stage
    logic                          p_vld_reg;
    logic [stac_pkg::CNT_W-1:0]    p_off_reg;
    logic                          p_inr_reg;
    logic [stac_pkg::IDX_W-1:0]    p_idx_reg;
    logic [stac_pkg::TAG_W-1:0]    rd_tag_reg;

    // result and output
    logic [stac_pkg::STATUS_W-1:0] res_status_reg;
    logic [stac_pkg::CNT_W-1:0]    res_off_reg;
    logic                          fill_bad_reg;
    logic [stac_pkg::STATUS_W-1:0] out_status_reg;
    logic [stac_pkg::CNT_W-1:0]    out_off_reg;

    // clearing pass
    logic [stac_pkg::IDX_W-1:0]    clr_idx_reg;

    logic                          is_ls;
    logic                          is_store;
    logic                          is_fill;
    logic                          is_probe;
    logic [stac_pkg::CNT_W-1:0]    count_eff;
    logic                          unchecked;
    logic                          pre_done;
    logic [stac_pkg::STATUS_W-1:0] pre_status;
    logic                          issue_go;
    logic                          in_range;
    logic                          s2_set;
    logic [stac_pkg::STATUS_W-1:0] s2_status;
    logic                          s2_fix;
    logic                          s2_stop;
    logic                          mem_we;
    logic [stac_pkg::IDX_W-1:0]    mem_waddr;
    logic [stac_pkg::TAG_W-1:0]    mem_wdata;

    assign is_store  = (mode_reg == stac_pkg::MODE_STORE);
    assign is_ls     = (mode_reg == stac_pkg::MODE_LOAD) || is_store;
    assign is_fill   = (mode_reg == stac_pkg::MODE_FILL);
    assign is_probe  = (mode_reg == stac_pkg::MODE_PROBE);
    assign count_eff = is_probe ? stac_pkg::CNT_W'(1) : count_reg;
    assign unchecked = !cen_reg || (addr_reg >= limit_reg);

    // early outcome of loads, stores and empty fills
    always_comb begin
        pre_done   = 1'b0;
        pre_status = stac_pkg::ST_OK;
        if (is_ls) begin
            priority if (unchecked) begin
                pre_done = 1'b1;
            end else if (addr_reg == '0) begin
                pre_done   = 1'b1;
                pre_status = stac_pkg::ST_NULL;
            end else if (addr_reg <= base_reg) begin
                pre_done   = 1'b1;
                pre_status = stac_pkg::ST_INVALID;
            end else begin
                pre_done = (count_reg == '0);
            end
        end else if (is_fill) begin
            pre_done = (count_reg == '0);
        end
    end

    assign issue_go = (cur_off_reg < count_eff);
    assign in_range = (cur_idx_reg < stac_pkg::ADDR_W'(stac_pkg::SHADOW_DEPTH));

    // tag check of the byte whose tag was read in the previous cycle
    always_comb begin
        s2_set    = 1'b0;
        s2_fix    = 1'b0;
        s2_status = stac_pkg::ST_OK;
        if (!p_inr_reg) begin
            s2_set    = 1'b1;
            s2_status = stac_pkg::ST_INVALID;
        end else if (is_probe) begin
            if (rd_tag_reg == stac_pkg::TAG_FREED) begin
                s2_set    = 1'b1;
                s2_status = stac_pkg::ST_DFREE;
            end
        end else begin
            unique case (rd_tag_reg)
                stac_pkg::TAG_VALID: begin
                end
                stac_pkg::TAG_FREED: begin
                    s2_set    = 1'b1;
                    s2_status = stac_pkg::ST_UAF;
                end
                stac_pkg::TAG_NOTALLOC: begin
                    s2_set    = 1'b1;
                    s2_status = stac_pkg::ST_UNALLOC;
                end
                stac_pkg::TAG_UNINIT: begin
                    if (is_store) begin
                        s2_fix = 1'b1;
                    end else begin
                        s2_set    = 1'b1;
                        s2_status = stac_pkg::ST_UNINIT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s2_stop = p_vld_reg && s2_set;

    assign sts.clr_done = (clr_idx_reg == stac_pkg::IDX_W'(stac_pkg::SHADOW_DEPTH - 1));
    assign sts.pre_done = pre_done;
    assign sts.run_done = is_fill ? !issue_go : (s2_stop || (p_vld_reg && !issue_go));

    // single write port: clearing pass, fill, or store fix-up
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = stac_pkg::TAG_VALID;
        priority if (cmd.clear) begin
            mem_we = 1'b1;
        end else if (cmd.run && is_fill) begin
            mem_we    = issue_go && in_range;
            mem_waddr = cur_idx_reg[stac_pkg::IDX_W-1:0];
            mem_wdata = tag_reg;
        end else if (cmd.run) begin
            mem_we    = p_vld_reg && s2_fix;
            mem_waddr = p_idx_reg;
        end else begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.run && !is_fill && issue_go && in_range) begin
            rd_tag_reg <= mem[cur_idx_reg[stac_pkg::IDX_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_reg     <= 1'b0;
            base_reg    <= '0;
            limit_reg   <= '0;
            clr_idx_reg <= '0;
            p_vld_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    stac_pkg::CFG_CHECK_ENABLE: cen_reg   <= cfg_wdata[0];
                    stac_pkg::CFG_KERNEL_BASE:  base_reg  <= cfg_wdata;
                    stac_pkg::CFG_CHECK_LIMIT:  limit_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + stac_pkg::IDX_W'(1);
            end
            if (cmd.prep) begin
                p_vld_reg <= 1'b0;
            end else if (cmd.run) begin
                p_vld_reg <= issue_go && !is_fill;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            addr_reg  <= in_access_address;
            count_reg <= in_byte_count;
            tag_reg   <= in_fill_tag;
        end
        if (cmd.prep) begin
            cur_idx_reg    <= addr_reg - base_reg;
            cur_off_reg    <= '0;
            fill_bad_reg   <= 1'b0;
            res_status_reg <= pre_status;
            res_off_reg    <= '0;
        end else if (cmd.run) begin
            if (issue_go) begin
                cur_idx_reg <= cur_idx_reg + stac_pkg::ADDR_W'(1);
                cur_off_reg <= cur_off_reg + stac_pkg::CNT_W'(1);
                p_off_reg   <= cur_off_reg;
                p_inr_reg   <= in_range;
                p_idx_reg   <= cur_idx_reg[stac_pkg::IDX_W-1:0];
            end
            if (is_fill) begin
                if (issue_go && !in_range && !fill_bad_reg) begin
                    fill_bad_reg   <= 1'b1;
                    res_status_reg <= stac_pkg::ST_INVALID;
                    res_off_reg    <= cur_off_reg;
                end
            end else if (s2_stop) begin
                res_status_reg <= s2_status;
                res_off_reg    <= p_off_reg;
            end
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
        end
    end

    assign out_status       = out_status_reg;
    assign out_fault_offset = out_off_reg;

endmodule

`default_nettype wire

/* src/stac_ctrl.sv */
// controller: clearing pass, request sequencing and result handshake
`default_nettype none

module stac_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire stac_pkg::sts_t   sts,
    output stac_pkg::cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.pre_done ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                cmd.run = 1'b1;
                if (sts.run_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.out_load) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tvalid = out_vld_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_vld_reg || m_tready))
        else $error("result register overwritten while still pending");

    a_accept_to_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted request not taken into prep");

    a_run_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && sts.run_done) |=> (state_reg == ST_DONE))
        else $error("finished byte walk did not reach done");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_tvalid)
        else $error("result offered during clearing pass");
`endif

endmodule

`default_nettype wire

/* src/shadow_tag_access_checker_unit.sv */
// top level of the shadow tag access checker
`default_nettype none

// Shadow tag access checker: one 2-bit tag per shadow byte (valid, freed, not
// allocated, uninitialized) held in an on-chip memory of SHADOW_DEPTH entries.
// Each request (mode on s_tuser) returns exactly one result on m_tdata: a
// status code and the offset of the first failing byte. After reset the
// block runs a clearing pass over all SHADOW_DEPTH entries that sets every
// tag to valid; s_tready stays low until it ends, while config writes are
// taken at any time. The memory has one read and one write port, and the
// byte walk reads one tag per cycle with the check of byte i overlapping the
// read of byte i+1. A load, store or fill walks its n bytes, a double-free
// probe walks one byte, and a request settled without touching memory
// (window off, null, invalid base, zero length) skips the walk; a failing
// byte ends a load or store walk early. The result sits in an output
// register, so the next request is taken while it waits on m_tready.
// Config registers are meant to be written only while the block is idle.
module shadow_tag_access_checker_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // request channel
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // access_address [63:0], byte_count [76:64], fill_tag [78:77], zero pad
    input  wire logic [stac_pkg::S_TDATA_W-1:0]         s_tdata,
    // mode [1:0]
    input  wire logic [stac_pkg::MODE_W-1:0]            s_tuser,
    // result channel
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // status [2:0], fault_offset [15:3]
    output logic      [stac_pkg::M_TDATA_W-1:0]         m_tdata,
    // config write port
    input  wire logic                                   cfg_we,
    input  wire logic [stac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [stac_pkg::CFG_W-1:0]             cfg_wdata
);

    stac_pkg::cmd_t                   cmd;
    stac_pkg::sts_t                   sts;
    logic [stac_pkg::STATUS_W-1:0]    out_status;
    logic [stac_pkg::CNT_W-1:0]       out_fault_offset;

    // sequencing: clearing pass, accept, prep, byte walk, result hand-off
    stac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tag memory, config registers and result formation
    stac_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .in_mode           (s_tuser),
        .in_access_address (s_tdata[stac_pkg::S_ADDR_LO +: stac_pkg::ADDR_W]),
        .in_byte_count     (s_tdata[stac_pkg::S_CNT_LO +: stac_pkg::CNT_W]),
        .in_fill_tag       (s_tdata[stac_pkg::S_TAG_LO +: stac_pkg::TAG_W]),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .out_status        (out_status),
        .out_fault_offset  (out_fault_offset)
    );

    // result packing, status in the low bits
    assign m_tdata = stac_pkg::M_TDATA_W'({out_fault_offset, out_status});

endmodule

`default_nettype wire
